### sv/tlb_page_table_translator_unit_macros.svh
// ----------------------------------------------------------------------------
// TLB translator assertion macros
// Shared concurrent assertion forms for the translator checker.
// ----------------------------------------------------------------------------
`ifndef TLB_PAGE_TABLE_TRANSLATOR_UNIT_MACROS_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_UNIT_MACROS_SVH

// assertion sampled on the rising clock, off while reset is high
`define TLBPT_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// assertion sampled on the rising clock, also checked during reset
`define TLBPT_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

### sv/tlbpt_pkg.sv
// ----------------------------------------------------------------------------
// TLB translator package
// Field widths and the TLB entry type shared by the translator modules.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

  localparam int ADDR_W   = 16;
  localparam int PAGE_W   = 8;
  localparam int OFFSET_W = 8;
  localparam int FRAME_W  = 8;
  localparam int PAGES    = 256;

  // output beat layout
  localparam int TDATA_W    = 32;
  localparam int TUSER_W    = 2;
  localparam int USER_HIT   = 0;
  localparam int USER_FAULT = 1;

  typedef logic [PAGE_W-1:0]   page_t;
  typedef logic [OFFSET_W-1:0] offset_t;
  typedef logic [FRAME_W-1:0]  frame_t;

  typedef struct packed {
    logic   valid;
    page_t  page;
    frame_t frame;
  } tlb_entry_t;

endpackage

### sv/tlbpt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tlbpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### sv/tlbpt_cell.sv
// ----------------------------------------------------------------------------
// TLB cell
// One TLB entry. On insert it takes its neighbor's entry and hands its own
// on, so the row ages entries out in FIFO order. Compares against the key.
// ----------------------------------------------------------------------------
module tlbpt_cell import tlbpt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       shift,
  input  tlb_entry_t entry_in,
  output tlb_entry_t entry_out,
  input  page_t      key,
  output logic       match
);

  logic   valid;
  page_t  page;
  frame_t frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= entry_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      page  <= entry_in.page;
      frame <= entry_in.frame;
    end
  end

  assign entry_out = '{valid: valid, page: page, frame: frame};
  assign match     = valid && (page == key);

endmodule

### sv/tlb_page_table_translator_unit.sv
// Steps: the page table RAM is read as the input beat is accepted, then the
// LOOK state updates table and TLB and registers the result beat. A new address
// is taken only once the previous one has left LOOK, which waits while a result beat is stalled.
// Reset (synchronous): clears TLB and page table valid bits and the frame
// counter at once; frame RAM is not cleared, no clearing pass.
// ----------------------------------------------------------------------------
// TLB page table translator
// Translates a 16-bit logical address through a FIFO TLB built as a row of
// shifting cells and a 256-entry page table, assigning frames on faults.
// ----------------------------------------------------------------------------
module tlb_page_table_translator_unit import tlbpt_pkg::*; #(
  parameter int TLB_ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [ADDR_W-1:0]  s_tdata,   // [15:0] virt_addr
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // [15:0] phys_addr,
                                        // [23:16] frame_num, [31:24] fault_page
  output logic [TUSER_W-1:0] m_tuser    // [0] tlb_hit, [1] page_fault
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOOK = 1'b1;

  logic             state;
  page_t            page_q;
  offset_t          offset_q;
  frame_t           free_frame;
  logic [PAGES-1:0] pt_valid;

  tlb_entry_t       ents [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] match;
  tlb_entry_t       new_entry;

  logic   tlb_any;
  frame_t tlb_frame;
  frame_t ram_frame;
  page_t  rd_page;
  logic   fire;
  logic   pt_hit;
  logic   fault;
  logic   insert;
  frame_t frame;

  assign s_tready = (state == ST_IDLE);
  assign fire     = (state == ST_LOOK) && (!m_tvalid || m_tready);
  assign rd_page  = (state == ST_IDLE) ? s_tdata[ADDR_W-1:OFFSET_W] : page_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: if (s_tvalid) state <= ST_LOOK;
        ST_LOOK: if (fire)     state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      page_q   <= s_tdata[ADDR_W-1:OFFSET_W];
      offset_q <= s_tdata[OFFSET_W-1:0];
    end
  end

  tlbpt_ram #(
    .WIDTH(FRAME_W),
    .DEPTH(PAGES)
  ) u_pt_ram (
    .clk    (clk),
    .we     (fire && fault),
    .wr_addr(page_q),
    .wr_data(free_frame),
    .rd_addr(rd_page),
    .rd_data(ram_frame)
  );

  // TLB row: new entries enter cell 0, the oldest drops off the far end
  assign new_entry = '{valid: 1'b1, page: page_q, frame: frame};

  for (genvar i = 0; i < TLB_ENTRIES; i++) begin : g_cell
    tlbpt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (insert),
      .entry_in ((i == 0) ? new_entry : ents[(i == 0) ? 0 : i-1]),
      .entry_out(ents[i]),
      .key      (page_q),
      .match    (match[i])
    );
  end

  // refill only on a miss, so at most one cell matches
  always_comb begin
    tlb_any   = 1'b0;
    tlb_frame = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (match[i]) begin
        tlb_any   = 1'b1;
        tlb_frame = tlb_frame | ents[i].frame;
      end
    end
  end

  assign pt_hit = pt_valid[page_q];
  assign fault  = !tlb_any && !pt_hit;
  assign insert = fire && !tlb_any;

  always_comb begin
    if (tlb_any) begin
      frame = tlb_frame;
    end else if (pt_hit) begin
      frame = ram_frame;
    end else begin
      frame = free_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_valid   <= '0;
      free_frame <= '0;
    end else if (fire && fault) begin
      pt_valid[page_q] <= 1'b1;
      free_frame       <= free_frame + FRAME_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata             <= {(fault ? page_q : page_t'(0)), frame, frame, offset_q};
      m_tuser[USER_HIT]   <= tlb_any;
      m_tuser[USER_FAULT] <= fault;
    end
  end

endmodule

### sv/tlbpt_checker.sv
// ----------------------------------------------------------------------------
// TLB translator checker
// Port-level checks on the translator result beats and input pacing.
// ----------------------------------------------------------------------------
`include "tlb_page_table_translator_unit_macros.svh"

module tlbpt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser
);

  `TLBPT_ASSERT(a_stall_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")
  `TLBPT_ASSERT(a_hit_no_fault, clk, rst, m_tvalid |-> !(m_tuser[0] && m_tuser[1]), "TLB hit flagged together with a fault")
  `TLBPT_ASSERT(a_frame_in_addr, clk, rst, m_tvalid |-> (m_tdata[15:8] == m_tdata[23:16]) && ((m_tdata[31:24] == 8'd0) || m_tuser[1]), "frame and physical address disagree")
  `TLBPT_ASSERT(a_one_per_two, clk, rst, s_tvalid && s_tready |=> !s_tready, "input taken on consecutive cycles")
  `TLBPT_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !m_tvalid && s_tready, "block not idle after reset")

endmodule

bind tlb_page_table_translator_unit tlbpt_checker u_tlbpt_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tdata (s_tdata),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);

### sim/tlb_page_table_translator_unit_test.sv
// ----------------------------------------------------------------------------
// TLB page table translator testbench
// Drives logical addresses into the translator and checks every result beat
// against an in-bench model of the FIFO TLB, page table and frame allocator.
// A short directed table comes first, then random address streams with
// locality, so that TLB hits, page table refills and faults all show up.
// ----------------------------------------------------------------------------
module tlb_page_table_translator_unit_test import tlbpt_pkg::*;;

  localparam int TLB_N      = 16;
  localparam int DIR_N      = 23;
  localparam int RAND_N     = 1550;
  localparam int HIST_DEPTH = 48;
  localparam int HOLD_AT    = 700;
  localparam int CYCLE_MAX  = 200000;

  typedef struct packed {
    logic [ADDR_W-1:0] phys;
    frame_t            frame;
    logic              hit;
    logic              fault;
    page_t             fpage;
  } xlat_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    bit                known;
    xlat_t             want;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [ADDR_W-1:0]  s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;   // [15:0] phys_addr, [23:16] frame_num,
                                 // [31:24] fault_page
  logic [TUSER_W-1:0] m_tuser;   // [0] tlb_hit, [1] page_fault

  // model state
  bit     tlb_v  [TLB_N];
  page_t  tlb_pg [TLB_N];
  frame_t tlb_fr [TLB_N];
  int     ins_ptr = 0;
  bit     pt_v   [PAGES];
  frame_t pt_fr  [PAGES];
  logic [8:0] free_frame = '0;

  xlat_t     pending_xlat[$];
  page_t     page_hist[$];
  stim_row_t dir_rows[DIR_N];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  bit        calm = 1'b0;
  xlat_t     head;

  tlb_page_table_translator_unit #(.TLB_ENTRIES(TLB_N)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #10 clk = ~clk;

  function automatic void tlb_fill(input page_t pg, input frame_t fr);
    tlb_pg[ins_ptr] = pg;
    tlb_fr[ins_ptr] = fr;
    tlb_v[ins_ptr]  = 1'b1;
    ins_ptr = (ins_ptr == TLB_N - 1) ? 0 : ins_ptr + 1;
  endfunction

  // one translation, updating TLB, page table and frame counter
  function automatic xlat_t translate_addr(input logic [ADDR_W-1:0] la);
    xlat_t   r;
    page_t   pg;
    offset_t off;
    bit      found;
    pg    = la[15:8];
    off   = la[7:0];
    found = 1'b0;
    r     = '0;
    for (int i = 0; i < TLB_N; i++) begin
      if (!found && tlb_v[i] && tlb_pg[i] == pg) begin
        found   = 1'b1;
        r.frame = tlb_fr[i];
      end
    end
    r.hit = found;
    if (!found) begin
      if (pt_v[pg]) begin
        r.frame = pt_fr[pg];
      end else begin
        r.fault    = 1'b1;
        r.fpage    = pg;
        r.frame    = free_frame[7:0];
        pt_fr[pg]  = free_frame[7:0];
        pt_v[pg]   = 1'b1;
        free_frame = free_frame + 9'd1;
      end
      tlb_fill(pg, r.frame);
    end
    r.phys = {r.frame, off};
    return r;
  endfunction

  task automatic send_addr(input logic [ADDR_W-1:0] la, input bit known, input xlat_t want);
    xlat_t pred;
    s_tvalid <= 1'b1;
    s_tdata  <= la;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = translate_addr(la);
    pending_xlat.push_back(known ? want : pred);
    if (!calm) begin
      while ($urandom_range(0, 99) < 32) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(0, 99) >= 32);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_MAX) begin
      $display("tlb_page_table_translator_unit_test NOT OK");
      $finish;
    end
  end

  // result beat checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_xlat.size() == 0) begin
        $error("result beat with no translation pending");
        mismatch_count++;
      end else begin
        head = pending_xlat.pop_front();
        if (m_tdata[15:0] !== head.phys) begin
          $error("phys_addr: expected %h, got %h", head.phys, m_tdata[15:0]);
          mismatch_count++;
        end
        if (m_tdata[23:16] !== head.frame) begin
          $error("frame_num: expected %h, got %h", head.frame, m_tdata[23:16]);
          mismatch_count++;
        end
        if (m_tuser[USER_HIT] !== head.hit) begin
          $error("tlb_hit: expected %b, got %b", head.hit, m_tuser[USER_HIT]);
          mismatch_count++;
        end
        if (m_tuser[USER_FAULT] !== head.fault) begin
          $error("page_fault: expected %b, got %b", head.fault, m_tuser[USER_FAULT]);
          mismatch_count++;
        end
        if (m_tdata[31:24] !== head.fpage) begin
          $error("fault_page: expected %h, got %h", head.fpage, m_tdata[31:24]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    page_t             pg;
    offset_t           off;
    int                r;
    logic [PAGE_W-1:0] sweep_page;
    sweep_page = '0;

    // fault, hit, fault at the top page, hit; then fill the TLB so both wrap out
    dir_rows[0]  = '{16'h0000, 1'b1, '{16'h0000, 8'h00, 1'b0, 1'b1, 8'h00}};
    dir_rows[1]  = '{16'h00FF, 1'b1, '{16'h00FF, 8'h00, 1'b1, 1'b0, 8'h00}};
    dir_rows[2]  = '{16'hFFFF, 1'b1, '{16'h01FF, 8'h01, 1'b0, 1'b1, 8'hFF}};
    dir_rows[3]  = '{16'hFF00, 1'b1, '{16'h0100, 8'h01, 1'b1, 1'b0, 8'h00}};
    dir_rows[4]  = '{16'h0180, 1'b0, '0};
    dir_rows[5]  = '{16'h0201, 1'b0, '0};
    dir_rows[6]  = '{16'h0302, 1'b0, '0};
    dir_rows[7]  = '{16'h0404, 1'b0, '0};
    dir_rows[8]  = '{16'h0508, 1'b0, '0};
    dir_rows[9]  = '{16'h0610, 1'b0, '0};
    dir_rows[10] = '{16'h0720, 1'b0, '0};
    dir_rows[11] = '{16'h0840, 1'b0, '0};
    dir_rows[12] = '{16'h0955, 1'b0, '0};
    dir_rows[13] = '{16'h0AAA, 1'b0, '0};
    dir_rows[14] = '{16'h0B7F, 1'b0, '0};
    dir_rows[15] = '{16'h0CFE, 1'b0, '0};
    dir_rows[16] = '{16'h0D01, 1'b0, '0};
    dir_rows[17] = '{16'h0EC3, 1'b0, '0};
    // 17th distinct page overwrites the oldest TLB slot
    dir_rows[18] = '{16'h0F7F, 1'b0, '0};
    // evicted pages come back from the page table, not as faults
    dir_rows[19] = '{16'h00AA, 1'b1, '{16'h00AA, 8'h00, 1'b0, 1'b0, 8'h00}};
    dir_rows[20] = '{16'hFF55, 1'b1, '{16'h0155, 8'h01, 1'b0, 1'b0, 8'h00}};
    dir_rows[21] = '{16'h0F80, 1'b0, '0};
    dir_rows[22] = '{16'h8001, 1'b0, '0};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      send_addr(dir_rows[i].addr, dir_rows[i].known, dir_rows[i].want);
      page_hist.push_back(dir_rows[i].addr[15:8]);
    end

    // random part: sweep for fresh faults, uniform random pages, working set for TLB hits,
    // older history for page table refills
    for (int n = 0; n < RAND_N; n++) begin
      calm = (n >= 200 && n < 450);
      r = $urandom_range(0, 99);
      if (r < 15) begin
        pg = sweep_page;
        sweep_page = sweep_page + 1'b1;
      end else if (r < 25) begin
        pg = page_t'($urandom_range(0, 255));
      end else if (r < 65) begin
        pg = page_hist[page_hist.size() - 1 - $urandom_range(0, 5)];
      end else begin
        pg = page_hist[$urandom_range(0, page_hist.size() - 1)];
      end
      r = $urandom_range(0, 99);
      off = (r < 10) ? 8'h00 : (r < 20) ? 8'hFF : 8'($urandom_range(0, 255));
      send_addr({pg, off}, 1'b0, '0);
      page_hist.push_back(pg);
      if (page_hist.size() > HIST_DEPTH) void'(page_hist.pop_front());
      if (n == HOLD_AT) begin
        // drain the pipe completely before going on
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_xlat.size() != 0) @(posedge clk);
      end
    end
    calm = 1'b0;
    s_tvalid <= 1'b0;

    while (pending_xlat.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tlb_page_table_translator_unit_test OK");
    end else begin
      $display("tlb_page_table_translator_unit_test NOT OK");
    end
    $finish;
  end

endmodule
